// ===== rtl/fgpd_pkg.sv =====
// Shared types, constants and helper functions for the fuzzy-gain PD steering block.
// Holds the microcode table, the fuzzy rule table and the quantiser thresholds.
// Depends on nothing.
package fgpd_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_BASE_P = 2'd0;
  localparam logic [1:0] REG_BASE_D = 2'd1;
  localparam logic [1:0] REG_FUZZY  = 2'd2;

  // Register reset values (8 fractional bits)
  localparam logic signed [23:0] BASE_P_RST = 24'sd51200;
  localparam logic signed [23:0] BASE_D_RST = -24'sd7680;
  localparam logic signed [23:0] FUZZY_RST  = 24'sd0;

  // Quantiser thresholds: error (scaled by 1/10) and error change
  localparam logic signed [16:0] E_T1 = 17'sd80;
  localparam logic signed [16:0] E_T2 = 17'sd240;
  localparam logic signed [16:0] E_T3 = 17'sd400;
  localparam logic signed [16:0] D_T1 = 17'sd8;
  localparam logic signed [16:0] D_T2 = 17'sd24;
  localparam logic signed [16:0] D_T3 = 17'sd40;

  // Fuzzy rule table, rows by error level, columns by error-change level
  localparam logic signed [3:0] RULE_TAB [7][7] = '{
    '{ 4'sd6,  4'sd5,  4'sd4,  4'sd3,  4'sd2,  4'sd1,  4'sd0},
    '{ 4'sd5,  4'sd5,  4'sd4,  4'sd3,  4'sd2,  4'sd0, -4'sd1},
    '{ 4'sd4,  4'sd4,  4'sd3,  4'sd2,  4'sd0, -4'sd2, -4'sd2},
    '{ 4'sd3,  4'sd3,  4'sd2,  4'sd0, -4'sd2, -4'sd3, -4'sd3},
    '{ 4'sd2,  4'sd2,  4'sd0, -4'sd2, -4'sd3, -4'sd4, -4'sd4},
    '{ 4'sd1,  4'sd0, -4'sd2, -4'sd3, -4'sd4, -4'sd5, -4'sd5},
    '{ 4'sd0, -4'sd1, -4'sd2, -4'sd3, -4'sd4, -4'sd5, -4'sd6}
  };

  // Output scaling: drive = floor((num + 1280) / 2560), done as >>> 8 then / 10
  localparam logic signed [47:0] SAMPLE_BIAS = 48'sd1280;
  localparam int unsigned        SAMPLE_SHIFT = 8;
  localparam logic [4:0]         SAMPLE_DIV   = 5'd10;

  // Constant divider: 40-bit dividend, four quotient bits per pass
  localparam int unsigned DIV_W     = 40;
  localparam int unsigned DIV_STEP  = 4;
  localparam int unsigned DIV_ITER  = DIV_W / DIV_STEP;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_ITER + 1);

  // Microprogram entry points
  localparam int unsigned PC_W      = 4;
  localparam logic [PC_W-1:0] PC_SAMPLE = 4'd0;
  localparam logic [PC_W-1:0] PC_TICK   = 4'd9;

  // Control word fields
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_FUZ,     // fuzzy_gain * |rule|
    MUL_PE,      // P * error
    MUL_DG,      // D * gyro
    MUL_TICK     // (new - old) * n
  } mul_sel_e;

  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_P,       // P = base_p + product
    ALU_X10,     // acc = 10 * product
    ALU_ADD_HI,  // acc += 16p or 8p, plus rounding bias
    ALU_ADD_LO,  // acc -= 2p or acc += 2p
    ALU_DIFF,    // acc = new - old
    ALU_TBIAS    // acc = product + half divisor
  } alu_op_e;

  typedef enum logic [1:0] {
    DIV_NONE,
    DIV_SAMPLE,  // divide acc >>> 8 by ten
    DIV_TICK     // divide acc by the sub-period count
  } div_op_e;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_WAIT,    // hold until the divider has finished
    SEQ_END      // hand over the result when the output register is free
  } seq_e;

  typedef enum logic [1:0] {
    FIN_NONE,
    FIN_SAMPLE,
    FIN_TICK
  } fin_e;

  typedef struct packed {
    mul_sel_e mul;
    alu_op_e  alu;
    div_op_e  div;
    seq_e     seq;
    fin_e     fin;
  } ucw_t;

  // Microprogram ROM
  function automatic ucw_t ucode(logic [PC_W-1:0] pc);
    ucw_t cw;
    cw.mul = MUL_NONE;
    cw.alu = ALU_NOP;
    cw.div = DIV_NONE;
    cw.seq = SEQ_NEXT;
    cw.fin = FIN_NONE;
    case (pc)
      4'd0:  cw.mul = MUL_FUZ;
      4'd1:  cw.alu = ALU_P;
      4'd2:  cw.mul = MUL_PE;
      4'd3: begin
        cw.mul = MUL_DG;
        cw.alu = ALU_X10;
      end
      4'd4:  cw.alu = ALU_ADD_HI;
      4'd5:  cw.alu = ALU_ADD_LO;
      4'd6:  cw.div = DIV_SAMPLE;
      4'd7:  cw.seq = SEQ_WAIT;
      4'd8: begin
        cw.seq = SEQ_END;
        cw.fin = FIN_SAMPLE;
      end
      4'd9:  cw.alu = ALU_DIFF;
      4'd10: cw.mul = MUL_TICK;
      4'd11: cw.alu = ALU_TBIAS;
      4'd12: cw.div = DIV_TICK;
      4'd13: cw.seq = SEQ_WAIT;
      4'd14: begin
        cw.seq = SEQ_END;
        cw.fin = FIN_TICK;
      end
      default: begin
        cw.seq = SEQ_END;
        cw.fin = FIN_NONE;
      end
    endcase
    return cw;
  endfunction

  // Quantise to a level and return it offset by three (0..6)
  function automatic logic [2:0] level_idx(logic signed [16:0] x,
                                           logic signed [16:0] t1,
                                           logic signed [16:0] t2,
                                           logic signed [16:0] t3);
    logic [2:0] idx;
    if (x >= t3)       idx = 3'd6;
    else if (x >= t2)  idx = 3'd5;
    else if (x >= t1)  idx = 3'd4;
    else if (x >= -t1) idx = 3'd3;
    else if (x >= -t2) idx = 3'd2;
    else if (x >= -t3) idx = 3'd1;
    else               idx = 3'd0;
    return idx;
  endfunction

  // Magnitude of a rule table entry
  function automatic logic [2:0] rule_mag(logic [2:0] row, logic [2:0] col);
    logic signed [3:0] v;
    v = 4'sd0;
    if (row <= 3'd6 && col <= 3'd6) begin
      v = RULE_TAB[row][col];
    end
    return v[3] ? 3'(-v) : v[2:0];
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic [31:0] sat32(logic signed [40:0] v);
    logic [31:0] r;
    if (v > 41'sd2147483647)       r = 32'h7fff_ffff;
    else if (v < -41'sd2147483648) r = 32'h8000_0000;
    else                           r = v[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/fuzzy_gain_pd_steering.sv =====
// Fuzzy-gain PD steering controller: microcoded sequencer, shared multiplier,
// radix-16 constant divider and output register.
// Depends on fgpd_pkg (microcode ROM, rule table, helpers).
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o): one request per item. op_i = 0 is a
//    control sample (path_error_i, gyro_rate_i); op_i = 1 is an interpolation tick
//    (sub_period_i). Every request yields exactly one drive_o result.
//  - Output channel (out_valid_o / out_stall_i): drive_o sits in an output
//    register; the next request is taken while a result still waits there.
//  - One request is in flight at a time: a new one is taken only after the
//    current result has been handed to the output register. The divider makes
//    ten passes of four quotient bits each over a 40-bit dividend.
//  - The multiplier (34 x 16 bits) is shared by all products of a request and
//    is followed by a register on every use.
//  - If the output register is still full and stalled when a result is ready,
//    the sequencer holds on its final step; nothing is lost or overwritten.
//  - Reset loads the default gains, clears the error/output history and leaves
//    both channels empty. The user writes gains via cfg_we_i only while idle; the block does not enforce it.
module fuzzy_gain_pd_steering #(
  parameter int unsigned SUB_PERIODS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic signed [15:0] path_error_i,
  input  logic signed [15:0] gyro_rate_i,
  input  logic [3:0]         sub_period_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] drive_o
);

  localparam int unsigned       NW      = $clog2(SUB_PERIODS + 1);
  localparam logic [4:0]        SUBS_C  = 5'(SUB_PERIODS);
  localparam logic signed [47:0] HALF_C = 48'(SUB_PERIODS / 2);
  localparam int unsigned       DW      = fgpd_pkg::DIV_W;

  // Configuration and history
  logic signed [23:0] base_p_q, base_d_q, fuzzy_q;
  logic signed [15:0] last_error_q;
  logic signed [31:0] new_q, old_q;

  // Sequencer
  logic                          busy_q;
  logic [fgpd_pkg::PC_W-1:0]     pc_q;
  fgpd_pkg::ucw_t                cw;
  logic                          in_acc, out_free, fin_go;

  // Datapath
  logic signed [15:0] e_q, g_q;
  logic [NW-1:0]      n_q;
  logic [2:0]         r_q;
  logic signed [27:0] p_q;
  logic signed [49:0] prod_q;
  logic signed [47:0] acc_q;
  logic signed [31:0] drive_q;
  logic               out_valid_q;

  // Divider
  logic [DW-1:0]                   dq_q;
  logic [3:0]                      rem_q;
  logic [4:0]                      dsr_q;
  logic                            neg_q;
  logic [fgpd_pkg::DIV_CNT_W-1:0]  cnt_q;

  assign cw         = fgpd_pkg::ucode(pc_q);
  assign in_stall_o = busy_q;
  assign in_acc     = in_valid_i && !busy_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fin_go     = busy_q && (cw.seq == fgpd_pkg::SEQ_END) && out_free;

  // Rule lookup from the incoming error and its change
  logic signed [16:0] err_x, derr_x;
  logic [2:0]         rule_r;
  logic [4:0]         np1;
  logic [NW-1:0]      n_d;

  always_comb begin
    err_x  = 17'(path_error_i);
    derr_x = err_x - 17'(last_error_q);
    rule_r = fgpd_pkg::rule_mag(
      fgpd_pkg::level_idx(err_x, fgpd_pkg::E_T1, fgpd_pkg::E_T2, fgpd_pkg::E_T3),
      fgpd_pkg::level_idx(derr_x, fgpd_pkg::D_T1, fgpd_pkg::D_T2, fgpd_pkg::D_T3));
    np1    = 5'(sub_period_i) + 5'd1;
    n_d    = (np1 > SUBS_C) ? NW'(SUB_PERIODS) : np1[NW-1:0];
  end

  // Shared multiplier operand selection
  logic signed [33:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [49:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cw.mul)
      fgpd_pkg::MUL_FUZ: begin
        mul_a = 34'(fuzzy_q);
        mul_b = 16'(r_q);
      end
      fgpd_pkg::MUL_PE: begin
        mul_a = 34'(p_q);
        mul_b = e_q;
      end
      fgpd_pkg::MUL_DG: begin
        mul_a = 34'(base_d_q);
        mul_b = g_q;
      end
      fgpd_pkg::MUL_TICK: begin
        mul_a = acc_q[33:0];
        mul_b = 16'(n_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Accumulator ALU
  logic signed [47:0] prod48, acc_d;
  logic               e_pos;

  always_comb begin
    prod48 = prod_q[47:0];
    e_pos  = !e_q[15] && (e_q != 16'sd0);
    acc_d  = acc_q;
    case (cw.alu)
      fgpd_pkg::ALU_X10:    acc_d = (prod48 <<< 3) + (prod48 <<< 1);
      fgpd_pkg::ALU_ADD_HI: acc_d = acc_q + (e_pos ? (prod48 <<< 4) : (prod48 <<< 3))
                                    + fgpd_pkg::SAMPLE_BIAS;
      fgpd_pkg::ALU_ADD_LO: acc_d = e_pos ? (acc_q - (prod48 <<< 1))
                                          : (acc_q + (prod48 <<< 1));
      fgpd_pkg::ALU_DIFF:   acc_d = 48'(new_q) - 48'(old_q);
      fgpd_pkg::ALU_TBIAS:  acc_d = prod48 + HALF_C;
      default:              acc_d = acc_q;
    endcase
  end

  // Divider operand and one pass of four restoring steps
  logic [DW-1:0] div_x, dq_v;
  logic [3:0]    rem_v;
  logic [4:0]    sh;

  always_comb begin
    div_x = (cw.div == fgpd_pkg::DIV_SAMPLE) ? acc_q[47:fgpd_pkg::SAMPLE_SHIFT]
                                             : acc_q[DW-1:0];
    dq_v  = dq_q;
    rem_v = rem_q;
    sh    = '0;
    for (int j = 0; j < fgpd_pkg::DIV_STEP; j++) begin
      sh   = {rem_v, dq_v[DW-1]};
      dq_v = {dq_v[DW-2:0], 1'b0};
      if (sh >= dsr_q) begin
        sh      = sh - dsr_q;
        dq_v[0] = 1'b1;
      end
      rem_v = sh[3:0];
    end
  end

  // Final value: undo the sign fold, add the old output for ticks, clamp
  logic [DW-1:0]      quo;
  logic signed [40:0] fin_sum;
  logic [31:0]        fin_val;

  always_comb begin
    quo     = neg_q ? ~dq_q : dq_q;
    fin_sum = {quo[DW-1], quo};
    if (cw.fin == fgpd_pkg::FIN_TICK) begin
      fin_sum = {{9{old_q[31]}}, old_q} + {quo[DW-1], quo};
    end
    fin_val = fgpd_pkg::sat32(fin_sum);
  end

  // Control state, configuration and history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      pc_q         <= fgpd_pkg::PC_SAMPLE;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      base_p_q     <= fgpd_pkg::BASE_P_RST;
      base_d_q     <= fgpd_pkg::BASE_D_RST;
      fuzzy_q      <= fgpd_pkg::FUZZY_RST;
      last_error_q <= '0;
      new_q        <= '0;
      old_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          fgpd_pkg::REG_BASE_P: base_p_q <= cfg_data_i;
          fgpd_pkg::REG_BASE_D: base_d_q <= cfg_data_i;
          fgpd_pkg::REG_FUZZY:  fuzzy_q  <= cfg_data_i;
          default: ;
        endcase
      end

      // step counter and jumps
      if (!busy_q) begin
        if (in_acc) begin
          busy_q <= 1'b1;
          pc_q   <= op_i ? fgpd_pkg::PC_TICK : fgpd_pkg::PC_SAMPLE;
        end
      end else begin
        case (cw.seq)
          fgpd_pkg::SEQ_NEXT: pc_q <= pc_q + 1'b1;
          fgpd_pkg::SEQ_WAIT: begin
            if (cnt_q == '0) pc_q <= pc_q + 1'b1;
          end
          fgpd_pkg::SEQ_END: begin
            if (out_free) busy_q <= 1'b0;
          end
          default: busy_q <= 1'b0;
        endcase
      end

      // divider pass counter
      if (busy_q && cw.div != fgpd_pkg::DIV_NONE) begin
        cnt_q <= fgpd_pkg::DIV_CNT_W'(fgpd_pkg::DIV_ITER);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end

      // output register
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // history update on a finished sample
      if (fin_go && cw.fin == fgpd_pkg::FIN_SAMPLE) begin
        old_q        <= new_q;
        new_q        <= fin_val;
        last_error_q <= e_q;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      e_q <= path_error_i;
      g_q <= gyro_rate_i;
      n_q <= n_d;
      r_q <= rule_r;
    end
    if (busy_q) begin
      if (cw.mul != fgpd_pkg::MUL_NONE) prod_q <= mul_p;
      if (cw.alu == fgpd_pkg::ALU_P) begin
        p_q <= 28'(base_p_q) + prod_q[27:0];
      end else if (cw.alu != fgpd_pkg::ALU_NOP) begin
        acc_q <= acc_d;
      end
      if (cw.div != fgpd_pkg::DIV_NONE) begin
        neg_q <= div_x[DW-1];
        dq_q  <= div_x[DW-1] ? ~div_x : div_x;
        rem_q <= '0;
        dsr_q <= (cw.div == fgpd_pkg::DIV_SAMPLE) ? fgpd_pkg::SAMPLE_DIV : SUBS_C;
      end
    end
    if (cnt_q != '0) begin
      dq_q  <= dq_v;
      rem_q <= rem_v;
    end
    if (fin_go) drive_q <= fin_val;
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

endmodule

// ===== test/tb_fuzzy_gain_pd_steering.sv =====
// Testbench for fuzzy_gain_pd_steering: directed table then random phases over
// several gain settings, every result checked against an in-bench steering model or a typed value.
// Depends on fgpd_pkg and the fuzzy_gain_pd_steering RTL.
`timescale 1ns / 100ps

module tb_fuzzy_gain_pd_steering;
  import fgpd_pkg::*;

  localparam int         SUB_PERIODS  = 10;
  localparam int         PHASES       = 8;
  localparam int         PHASE_ITEMS  = 205;
  localparam int         LIMIT_CYCLES = 400000;
  localparam int         HOLD_CYCLES  = 400;
  localparam logic       OP_SAMPLE    = 1'b0;
  localparam logic       OP_TICK      = 1'b1;
  localparam logic [1:0] REG_SPARE    = 2'd3;  // no register behind this index

  // Rule magnitudes, row = error level, column = change level, first entry in the MSBs
  localparam logic [195:0] RULE_MAG =
    196'h6543210_5543201_4432022_3320233_2202344_1023455_0123456;

  // One row of the directed table: a register write or a request
  typedef struct {
    bit                 is_cfg;
    logic [1:0]         idx;
    logic [23:0]        val;
    logic               op;
    logic signed [15:0] err;
    logic signed [15:0] gyro;
    logic [3:0]         sub;
    bit                 known;
    logic signed [31:0] drive;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_index_i = '0;
  logic [23:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               op_i = OP_SAMPLE;
  logic signed [15:0] path_error_i = '0;
  logic signed [15:0] gyro_rate_i = '0;
  logic [3:0]         sub_period_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] drive_o;

  // Stimulus modes shared by both sides
  logic calm = 1'b0;
  logic hold_req = 1'b0;
  bit   hold_taken = 1'b0;
  int   hold_left = 0;

  // Steering model state
  logic signed [23:0] gain_p = BASE_P_RST;
  logic signed [23:0] gain_d = BASE_D_RST;
  logic signed [23:0] gain_f = FUZZY_RST;
  logic signed [15:0] prev_error = '0;
  logic signed [31:0] drive_new = '0;
  logic signed [31:0] drive_old = '0;

  logic signed [31:0] drive_due [$];
  logic signed [31:0] want;
  dir_row_t           dir_tab [0:29];

  int errors = 0;
  int requests = 0;
  int samples = 0;
  int ticks = 0;
  int results = 0;
  int reg_writes = 0;
  int cycles = 0;
  int held_cycles = 0;

  fuzzy_gain_pd_steering #(.SUB_PERIODS(SUB_PERIODS)) uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .path_error_i (path_error_i),
    .gyro_rate_i  (gyro_rate_i),
    .sub_period_i (sub_period_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .drive_o      (drive_o)
  );

  always #5 clk = ~clk;

  // Division rounding towards minus infinity, divisor positive
  function automatic longint floor_div(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Quantise to seven levels, returned as 0..6
  function automatic int quant_level(longint x, longint t1, longint t2, longint t3);
    if (x >= t3) return 6;
    if (x >= t2) return 5;
    if (x >= t1) return 4;
    if (x >= -t1) return 3;
    if (x >= -t2) return 2;
    if (x >= -t3) return 1;
    return 0;
  endfunction

  // Expected drive for one accepted request; updates the history on a sample
  function automatic logic signed [31:0] steer_drive(logic op, logic signed [15:0] e,
                                                     logic signed [15:0] g, logic [3:0] k);
    longint err, chg, mag, p, m, num, n, diff, res;
    int     row, col;
    if (op == OP_SAMPLE) begin
      err = e;
      chg = err - longint'(prev_error);
      row = quant_level(err, 80, 240, 400);
      col = quant_level(chg, 8, 24, 40);
      mag = RULE_MAG[195 - 4 * (row * 7 + col) -: 4];
      p   = longint'(gain_p) + longint'(gain_f) * mag;
      m   = (err > 0) ? 14 : 10;
      num = 10 * p * err + m * longint'(gain_d) * longint'(g);
      res = clamp32(floor_div(num + 1280, 2560));
      drive_old  = drive_new;
      drive_new  = res[31:0];
      prev_error = e;
    end else begin
      n = longint'(k) + 1;
      if (n > SUB_PERIODS) n = SUB_PERIODS;  // late sub-period holds at the new output
      diff = longint'(drive_new) - longint'(drive_old);
      res  = clamp32(longint'(drive_old) +
                     floor_div(diff * n + SUB_PERIODS / 2, SUB_PERIODS));
    end
    return res[31:0];
  endfunction

  // Path error: mostly a walk near the last one or near the thresholds
  function automatic logic signed [15:0] next_error();
    int v;
    case ($urandom_range(9))
      0, 1:       v = $signed(16'($urandom));
      2, 3, 4, 5: v = int'(prev_error) + int'($urandom_range(0, 120)) - 60;
      default:    v = int'($urandom_range(0, 1000)) - 500;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] next_gyro();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 400)) - 200);
  endfunction

  function automatic logic [23:0] rand_gain();
    logic signed [23:0] raw;
    raw = 24'($urandom);
    return raw >>> $urandom_range(0, 20);
  endfunction

  // Offer one request, wait for it to be taken, then maybe idle
  task automatic offer(logic op, logic signed [15:0] e, logic signed [15:0] g,
                       logic [3:0] k, bit known, logic signed [31:0] typed);
    logic signed [31:0] pred;
    in_valid_i   <= 1'b1;
    op_i         <= op;
    path_error_i <= e;
    gyro_rate_i  <= g;
    sub_period_i <= k;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    pred = steer_drive(op, e, g, k);
    drive_due.push_back(known ? typed : pred);
    requests++;
    if (op == OP_SAMPLE) samples++;
    else ticks++;
    if (!calm && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every outstanding result
  task automatic settle();
    in_valid_i <= 1'b0;
    while (drive_due.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk);
    cfg_we_i <= 1'b0;
    reg_writes++;
    case (idx)
      REG_BASE_P: gain_p = val;
      REG_BASE_D: gain_d = val;
      REG_FUZZY:  gain_f = val;
      default: ;  // write is dropped
    endcase
    @(posedge clk);
  endtask

  // Result side: check each result, stall at random or for the long hold-off
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid_o && !out_stall_i) begin
        if (drive_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected drive result, expected none, got %0d", $time, drive_o);
        end else begin
          want = drive_due.pop_front();
          results++;
          if (drive_o !== want) begin
            errors++;
            $display("%0t: drive mismatch, expected %0d, got %0d", $time, want, drive_o);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 7);
      end
    end
  end

  // Run limit and input back-pressure count
  always @(posedge clk) begin
    cycles++;
    if (in_valid_i && in_stall_o) held_cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int  ph, start, j, burst, pick;
    bit  paused;
    logic [23:0] gp, gd, gf;

    // Directed requests and register writes; typed results only where the arithmetic is trivial
    dir_tab = '{
      '{0, 2'd0, 24'd0, OP_TICK,   16'sd0,      16'sd0,      4'd0,  1, 32'sd0},
      '{0, 2'd0, 24'd0, OP_SAMPLE, 16'sd0,      16'sd0,      4'd0,  1, 32'sd0},
      '{0, 2'd0, 24'd0, OP_SAMPLE, 16'sd32767,  16'sd0,      4'd0,  1, 32'sd6553400},
      '{0, 2'd0, 24'd0, OP_SAMPLE, -16'sd32768, 16'sd32767,  4'd0,  1, -32'sd7536610},
      '{0, 2'd0, 24'd0, OP_SAMPLE, 16'sd1,      -16'sd32768, 4'd0,  1, 32'sd1376456},
      '{0, 2'd0, 24'd0, OP_TICK,   16'sd0,      16'sd0,      4'd15, 1, 32'sd1376456},
      '{0, 2'd0, 24'd0, OP_TICK,   16'sd0,      16'sd0,      4'd9,  1, 32'sd1376456},
      '{0, 2'd0, 24'd0, OP_TICK,   16'sd0,      16'sd0,      4'd0,  0, 32'sd0},
      '{0, 2'd0, 24'd0, OP_TICK,   16'sd0,      16'sd0,      4'd4,  0, 32'sd0},
      '{1, REG_FUZZY, 24'd2560, OP_SAMPLE, 16'sd0, 16'sd0,   4'd0,  0, 32'sd0},
      '{0, 2'd0, 24'd0, OP_SAMPLE, 16'sd400,    16'sd16,     4'd0,  0, 32'sd0},
      '{0, 2'd0, 24'd0, OP_SAMPLE, 16'sd440,    -16'sd16,    4'd0,  0, 32'sd0},
      '{0, 2'd0, 24'd0, OP_SAMPLE, 16'sd479,    16'sd0,      4'd0,  0, 32'sd0},
      '{0, 2'd0, 24'd0, OP_SAMPLE, 16'sd239,    16'sd0,      4'd0,  0, 32'sd0},
      '{0, 2'd0, 24'd0, OP_SAMPLE, 16'sd80,     16'sd0,      4'd0,  0, 32'sd0},
      '{0, 2'd0, 24'd0, OP_SAMPLE, 16'sd79,     16'sd0,      4'd0,  0, 32'sd0},
      '{0, 2'd0, 24'd0, OP_SAMPLE, -16'sd80,    16'sd0,      4'd0,  0, 32'sd0},
      '{0, 2'd0, 24'd0, OP_SAMPLE, -16'sd81,    16'sd0,      4'd0,  0, 32'sd0},
      '{0, 2'd0, 24'd0, OP_SAMPLE, -16'sd240,   16'sd0,      4'd0,  0, 32'sd0},
      '{0, 2'd0, 24'd0, OP_SAMPLE, -16'sd241,   16'sd0,      4'd0,  0, 32'sd0},
      '{0, 2'd0, 24'd0, OP_SAMPLE, -16'sd400,   16'sd0,      4'd0,  0, 32'sd0},
      '{0, 2'd0, 24'd0, OP_SAMPLE, -16'sd401,   16'sd0,      4'd0,  0, 32'sd0},
      '{1, REG_SPARE,  24'hffffff, OP_SAMPLE, 16'sd0, 16'sd0, 4'd0, 0, 32'sd0},
      '{1, REG_BASE_P, 24'h7fffff, OP_SAMPLE, 16'sd0, 16'sd0, 4'd0, 0, 32'sd0},
      '{1, REG_BASE_D, 24'h800000, OP_SAMPLE, 16'sd0, 16'sd0, 4'd0, 0, 32'sd0},
      '{1, REG_FUZZY,  24'h7fffff, OP_SAMPLE, 16'sd0, 16'sd0, 4'd0, 0, 32'sd0},
      '{0, 2'd0, 24'd0, OP_SAMPLE, 16'sd32767,  -16'sd32768, 4'd0,  1, 32'sh7fffffff},
      '{0, 2'd0, 24'd0, OP_SAMPLE, -16'sd32768, 16'sd32767,  4'd0,  1, 32'sh80000000},
      '{0, 2'd0, 24'd0, OP_TICK,   16'sd0,      16'sd0,      4'd0,  0, 32'sd0},
      '{0, 2'd0, 24'd0, OP_TICK,   16'sd0,      16'sd0,      4'd5,  0, 32'sd0}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) write_reg(dir_tab[i].idx, dir_tab[i].val);
      else offer(dir_tab[i].op, dir_tab[i].err, dir_tab[i].gyro, dir_tab[i].sub,
                 dir_tab[i].known, dir_tab[i].drive);
    end

    // Random phases, each under its own gain setting
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          gp = BASE_P_RST; gd = BASE_D_RST; gf = FUZZY_RST;
        end
        1: begin
          gp = 24'h800000; gd = 24'h800000; gf = 24'h800000;
        end
        2: begin
          gp = 24'h7fffff; gd = 24'h7fffff; gf = 24'h7fffff;
        end
        3: begin
          gp = 24'($urandom_range(0, 100000));
          gd = 24'(-$urandom_range(0, 20000));
          gf = 24'($urandom_range(0, 5000));
        end
        default: begin
          gp = rand_gain(); gd = rand_gain(); gf = rand_gain();
        end
      endcase
      write_reg(REG_BASE_P, gp);
      write_reg(REG_BASE_D, gd);
      write_reg(REG_FUZZY, gf);
      if (ph % 2 == 1) write_reg(REG_SPARE, 24'($urandom));

      if (ph == 4) calm <= 1'b1;
      if (ph == 5) hold_req <= 1'b1;
      paused = 0;
      start  = requests;
      while (requests - start < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          // sample followed by its run of interpolation ticks
          offer(OP_SAMPLE, next_error(), next_gyro(), 4'($urandom), 0, 0);
          burst = ($urandom_range(3) == 0) ? $urandom_range(1, SUB_PERIODS) : SUB_PERIODS;
          for (j = 0; j < burst; j++)
            offer(OP_TICK, 16'($urandom), 16'($urandom), 4'(j), 0, 0);
        end else if (pick < 85) begin
          offer(OP_TICK, 16'($urandom), 16'($urandom), 4'($urandom_range(15)), 0, 0);
        end else begin
          offer(OP_SAMPLE, 16'($urandom), 16'($urandom), 4'($urandom), 0, 0);
        end
        if (ph == 6 && !paused && requests - start > PHASE_ITEMS / 2) begin
          settle();
          paused = 1;
        end
      end
      if (ph == 4) calm <= 1'b0;
    end

    settle();
    repeat (30) @(posedge clk);
    $display("Ran %0d requests (%0d samples, %0d ticks), %0d results checked, %0d reg writes",
             requests, samples, ticks, results, reg_writes);
    $display("Input held off for %0d cycles across %0d gain settings",
             held_cycles, PHASES + 3);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fgpd_pkg.sv
rtl/fuzzy_gain_pd_steering.sv
test/tb_fuzzy_gain_pd_steering.sv
